// ===== rtl/core/efra_pkg.sv =====
// ----------------------------------------------------------------------------
// efra_pkg
// Shared widths, limits and state codes for the earliest free room assigner.
// ----------------------------------------------------------------------------
package efra_pkg;

  localparam int unsigned DefaultMaxRooms = 16;

  localparam int unsigned TimeW = 48;
  localparam int unsigned InTimeW = 32;
  localparam int unsigned UsesW = 32;
  localparam int unsigned RoomW = 4;
  localparam int unsigned CfgW = 5;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [UsesW-1:0] UsesMax = {UsesW{1'b1}};

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } efra_state_e;

endpackage

// ===== rtl/core/earliest_free_room_assigner.sv =====
// ----------------------------------------------------------------------------
// earliest_free_room_assigner
// Assigns each job to the lowest-numbered room free at its start, or else to
// the room that frees earliest, and tracks the busiest room.
// ----------------------------------------------------------------------------
// Usage:
// Jobs arrive on the input channel (in_valid_i / in_ready_o) as one beat
// carrying the requested start and finish time; jobs are expected in
// ascending start order. Every job yields one result beat on the output
// channel (out_valid_o / out_ready_i): the room it got, the time it really
// begins and the busiest room so far.
// A job goes through three steps: one to accept the beat and issue the
// first read, a scan that walks the free-at memory one room per cycle
// through its single read port over the rooms in use, and an update that
// reads back the use count and writes both memories. The result is
// registered when the update completes.
// The result sits in an output register, so a new job is accepted and
// scanned while the previous result waits. If the receiver stalls, the
// next job holds in its update state until the output register frees up.
// Reset clears all room times and use counts (through per-entry valid bits,
// no clearing pass) and sets the room count to the full capacity.
// The user must write the room count register through cfg_we_i / cfg_wdata_i
// only while the block is idle; the block itself does not enforce this. Zero
// is taken as one room, and values above the capacity as the full capacity.
// ----------------------------------------------------------------------------
module earliest_free_room_assigner
  import efra_pkg::*;
#(
  parameter int unsigned MAX_ROOMS = DefaultMaxRooms
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InTimeW-1:0] start_time_i,
  input  logic [InTimeW-1:0] finish_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RoomW-1:0]   assigned_room_o,
  output logic [TimeW-1:0]   actual_begin_o,
  output logic [RoomW-1:0]   busiest_room_o
);

  localparam int unsigned IdxW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ROOMS - 1);

  // Room memories, valid bits standing in for the cleared reset contents.
  logic [TimeW-1:0] free_mem [MAX_ROOMS];
  logic [UsesW-1:0] uses_mem [MAX_ROOMS];
  logic [MAX_ROOMS-1:0] free_vld_q, free_vld_d;
  logic [MAX_ROOMS-1:0] uses_vld_q, uses_vld_d;

  logic             free_re, free_we;
  logic [IdxW-1:0]  free_raddr, free_waddr;
  logic [TimeW-1:0] free_wdata, free_rdata_q, free_rd;
  logic             free_rvld_q;

  logic             uses_re, uses_we;
  logic [IdxW-1:0]  uses_addr;
  logic [UsesW-1:0] uses_wdata, uses_rdata_q, uses_rd;
  logic             uses_rvld_q;

  efra_state_e state_q, state_d;
  logic [IdxW-1:0] last_q, last_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pick_q, pick_d;
  logic [IdxW-1:0] best_room_q, best_room_d;
  logic [UsesW-1:0] best_uses_q, best_uses_d;
  logic [TimeW-1:0] earliest_q, earliest_d;
  logic [InTimeW-1:0] start_q;
  logic [InTimeW-1:0] dur_q;
  logic out_valid_q, out_valid_d;
  logic [IdxW-1:0] out_room_q;
  logic [TimeW-1:0] out_begin_q;
  logic [IdxW-1:0] out_best_q;

  logic             in_beat, out_load;
  logic [TimeW-1:0] start_ext, clamped;
  logic [TimeW:0]   end_sum;
  logic [TimeW-1:0] end_time;
  logic [UsesW-1:0] uses_next;

  assign in_beat = in_valid_i && in_ready_o;
  assign start_ext = TimeW'(start_q);
  assign free_rd = free_rvld_q ? free_rdata_q : '0;
  assign uses_rd = uses_rvld_q ? uses_rdata_q : '0;

  // A room that frees before the job starts is taken as free at the start.
  assign clamped = (free_rd < start_ext) ? start_ext : free_rd;

  assign end_sum = {1'b0, earliest_q} + (TimeW + 1)'(dur_q);
  assign end_time = end_sum[TimeW] ? TimeMax : end_sum[TimeW-1:0];
  assign uses_next = (uses_rd == UsesMax) ? uses_rd : uses_rd + 1'b1;

  // Room count register, kept as the index of the last room in use.
  always_comb begin
    last_d = last_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        last_d = '0;
      end else if (32'(cfg_wdata_i) > 32'(MAX_ROOMS)) begin
        last_d = LastIdx;
      end else begin
        last_d = IdxW'(32'(cfg_wdata_i) - 32'd1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pick_d      = pick_q;
    earliest_d  = earliest_q;
    best_room_d = best_room_q;
    best_uses_d = best_uses_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    free_re     = 1'b0;
    free_raddr  = '0;
    free_we     = 1'b0;
    free_waddr  = idx_q;
    free_wdata  = clamped;
    uses_re     = 1'b0;
    uses_we     = 1'b0;
    uses_addr   = pick_q;
    uses_wdata  = uses_next;
    free_vld_d  = free_vld_q;
    uses_vld_d  = uses_vld_q;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          free_re = 1'b1;
          idx_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        // Clamped time goes back so later out-of-order jobs see it.
        free_we = 1'b1;
        free_vld_d[idx_q] = 1'b1;
        if (idx_q == '0 || clamped < earliest_q) begin
          pick_d     = idx_q;
          earliest_d = clamped;
        end
        if (idx_q == last_q) begin
          uses_re   = 1'b1;
          uses_addr = pick_d;
          state_d   = StUpdate;
        end else begin
          idx_d      = idx_q + 1'b1;
          free_re    = 1'b1;
          free_raddr = idx_d;
        end
      end
      StUpdate: begin
        if (!out_valid_q || out_ready_i) begin
          free_we    = 1'b1;
          free_waddr = pick_q;
          free_wdata = end_time;
          free_vld_d[pick_q] = 1'b1;
          uses_we    = 1'b1;
          uses_vld_d[pick_q] = 1'b1;
          if (uses_next > best_uses_q ||
              (uses_next == best_uses_q && pick_q < best_room_q)) begin
            best_uses_d = uses_next;
            best_room_d = pick_q;
          end
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Room memories: one read port and one write port each.
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    if (free_re) begin
      free_rdata_q <= free_mem[free_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (uses_we) begin
      uses_mem[uses_addr] <= uses_wdata;
    end
    if (uses_re) begin
      uses_rdata_q <= uses_mem[uses_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_q      <= LastIdx;
      idx_q       <= '0;
      pick_q      <= '0;
      best_room_q <= '0;
      best_uses_q <= '0;
      out_valid_q <= 1'b0;
      free_vld_q  <= '0;
      uses_vld_q  <= '0;
      free_rvld_q <= 1'b0;
      uses_rvld_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      idx_q       <= idx_d;
      pick_q      <= pick_d;
      best_room_q <= best_room_d;
      best_uses_q <= best_uses_d;
      out_valid_q <= out_valid_d;
      free_vld_q  <= free_vld_d;
      uses_vld_q  <= uses_vld_d;
      if (free_re) begin
        free_rvld_q <= free_vld_q[free_raddr];
      end
      if (uses_re) begin
        uses_rvld_q <= uses_vld_q[uses_addr];
      end
    end
  end

  // Job payload and result registers.
  always_ff @(posedge clk_i) begin
    earliest_q <= earliest_d;
    if (in_beat) begin
      start_q <= start_time_i;
      dur_q   <= (finish_time_i > start_time_i) ? finish_time_i - start_time_i : '0;
    end
    if (out_load) begin
      out_room_q  <= pick_q;
      out_begin_q <= earliest_q;
      out_best_q  <= best_room_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign assigned_room_o = RoomW'(out_room_q);
  assign actual_begin_o  = out_begin_q;
  assign busiest_room_o  = RoomW'(out_best_q);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the earliest free room assigner. Jobs are pushed
// through the valid/ready input channel with random gaps, result beats are
// taken with random backpressure, and every result is compared field by field
// against a typed-in expectation or a behavioral predictor that keeps its own
// room times, use counts and room count.
// ----------------------------------------------------------------------------
module testbench;
  import efra_pkg::*;

  localparam int unsigned RoomCap = DefaultMaxRooms;
  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned ResetCycles = 6;
  // Even with random gaps and stalls, a full run of under two thousand jobs
  // stays far inside this limit, which leaves a wide margin.
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned IdlePct = 27;
  localparam int unsigned RandomPhases = 16;
  localparam int unsigned JobsPerPhase = 100;
  // One room fed with maximum-length jobs, pushing its free time far above
  // the 32-bit input range.
  localparam int unsigned SatJobs = 64;
  localparam int unsigned DirectedRows = 22;

  typedef enum logic {
    RowJob,
    RowCfg
  } plan_kind_e;

  // What one result beat should carry.
  typedef struct packed {
    logic [RoomW-1:0] room;
    logic [TimeW-1:0] begin_at;
    logic [RoomW-1:0] busiest;
  } assignment_t;

  // One row of the directed plan: either a room count write or a job. Rows
  // with known set use the typed-in expectation, the rest use the predictor.
  typedef struct packed {
    plan_kind_e         kind;
    logic [CfgW-1:0]    rooms;
    logic [InTimeW-1:0] start_t;
    logic [InTimeW-1:0] finish_t;
    logic               known;
    logic [RoomW-1:0]   room;
    logic [TimeW-1:0]   begin_at;
    logic [RoomW-1:0]   busiest;
  } plan_row_t;

  // Walk-through after reset (16 rooms, all free at zero):
  //  - a first job takes room 0, a second at the same start takes room 1,
  //    a later one takes room 2 since rooms 0 and 1 are still busy;
  //  - a job at the top of the time range lifts every room to that time and
  //    has zero length; a job that then asks for time zero is out of order
  //    and gets delayed; a job whose finish lies below its start is zero long;
  //  - room count 1, then 0 (taken as one room), then 2, then 31 (taken as
  //    the full capacity);
  //  - with two rooms, room 1 overtakes room 0 as busiest, and after a drop
  //    to one room the busiest stays room 1 although it is out of service.
  plan_row_t directed_plan [DirectedRows] = '{
    '{RowJob, 5'd0,  32'h0000_0000, 32'h0000_000A, 1'b1, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0000, 32'h0000_0005, 1'b1, 4'd1, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0003, 32'h0000_0004, 1'b1, 4'd2, 48'h3,           4'd0},
    '{RowJob, 5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'd0, 48'hFFFF_FFFF,   4'd0},
    '{RowJob, 5'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 4'd0, 48'hFFFF_FFFF,   4'd0},
    '{RowJob, 5'd0,  32'h0000_0007, 32'h0000_0002, 1'b1, 4'd1, 48'hFFFF_FFFF,   4'd0},
    '{RowCfg, 5'd1,  32'h0,         32'h0,         1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'd0, 48'h1_FFFF_FFFE, 4'd0},
    '{RowCfg, 5'd0,  32'h0,         32'h0,         1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 4'd0, 48'h1_FFFF_FFFE, 4'd0},
    '{RowCfg, 5'd2,  32'h0,         32'h0,         1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h8000_0000, 32'h8000_0001, 1'b1, 4'd1, 48'hFFFF_FFFF,   4'd0},
    '{RowCfg, 5'd31, 32'h0,         32'h0,         1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 4'd0, 48'h0,           4'd0},
    '{RowCfg, 5'd2,  32'h0,         32'h0,         1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0010, 32'h0000_0011, 1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0010, 32'h0000_0011, 1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0010, 32'h0000_0011, 1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0010, 32'h0000_0011, 1'b0, 4'd0, 48'h0,           4'd0},
    '{RowCfg, 5'd1,  32'h0,         32'h0,         1'b0, 4'd0, 48'h0,           4'd0},
    '{RowJob, 5'd0,  32'h0000_0012, 32'h0000_0013, 1'b0, 4'd0, 48'h0,           4'd0}
  };

  // Clock, reset and every block input start from known values.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               job_valid = 1'b0;
  logic               job_ready;
  logic [InTimeW-1:0] job_start = '0;
  logic [InTimeW-1:0] job_finish = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [RoomW-1:0]   res_room;
  logic [TimeW-1:0]   res_begin;
  logic [RoomW-1:0]   res_busiest;

  // Predictor state: a private copy of what the block should hold.
  logic [CfgW-1:0]  room_count_reg = CfgW'(RoomCap);
  logic [TimeW-1:0] room_free_time [RoomCap] = '{default: '0};
  logic [UsesW-1:0] room_job_count [RoomCap] = '{default: '0};
  logic [RoomW-1:0] top_room = '0;
  logic [UsesW-1:0] top_count = '0;

  // Results still owed by the block, oldest first.
  assignment_t pending_assignments [$];

  int unsigned idle_pct = IdlePct;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  earliest_free_room_assigner i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (job_valid),
    .in_ready_o     (job_ready),
    .start_time_i   (job_start),
    .finish_time_i  (job_finish),
    .out_valid_o    (res_valid),
    .out_ready_i    (res_ready),
    .assigned_room_o(res_room),
    .actual_begin_o (res_begin),
    .busiest_room_o (res_busiest)
  );

  // Zero means one room, anything past the capacity means all of them.
  function automatic int unsigned rooms_in_service();
    if (room_count_reg == '0) return 1;
    if (32'(room_count_reg) > RoomCap) return RoomCap;
    return 32'(room_count_reg);
  endfunction

  // Adds two 32-bit times and clamps at the top of the input range.
  function automatic logic [InTimeW-1:0] clamp_add(input logic [InTimeW-1:0] a,
                                                   input logic [InTimeW-1:0] b);
    logic [InTimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[InTimeW] ? '1 : sum[InTimeW-1:0];
  endfunction

  // Assigns one job to a room and updates the predictor state. Every room in
  // service is first lifted to the job's start, so a room already free
  // shows up with exactly the start time and the lowest such index wins.
  task automatic assign_room(input logic [InTimeW-1:0] start_t,
                             input logic [InTimeW-1:0] finish_t,
                             output assignment_t result);
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] earliest;
    logic [TimeW:0]   done_at;
    int unsigned      n;
    int unsigned      pick;
    span = (finish_t > start_t) ? TimeW'(finish_t - start_t) : '0;
    n = rooms_in_service();
    pick = 0;
    earliest = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (room_free_time[i] < TimeW'(start_t)) room_free_time[i] = TimeW'(start_t);
      if (i == 0 || room_free_time[i] < earliest) begin
        pick = i;
        earliest = room_free_time[i];
      end
    end
    done_at = {1'b0, earliest} + {1'b0, span};
    room_free_time[pick] = done_at[TimeW] ? TimeMax : done_at[TimeW-1:0];
    if (room_job_count[pick] != UsesMax) room_job_count[pick]++;
    // The busiest room only moves on a strictly higher count, or on an equal
    // count held by a lower index.
    if (room_job_count[pick] > top_count ||
        (room_job_count[pick] == top_count && pick < 32'(top_room))) begin
      top_count = room_job_count[pick];
      top_room = RoomW'(pick);
    end
    result.room = RoomW'(pick);
    result.begin_at = earliest;
    result.busiest = top_room;
  endtask

  // Presents one job beat, holding it until the block takes it. A gap drops
  // valid first; otherwise valid stays high straight into the next beat.
  task automatic send_job(input logic [InTimeW-1:0] start_t,
                          input logic [InTimeW-1:0] finish_t,
                          input logic known,
                          input assignment_t typed);
    assignment_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      job_valid <= 1'b0;
      @(posedge clk);
    end
    job_valid <= 1'b1;
    job_start <= start_t;
    job_finish <= finish_t;
    do @(posedge clk); while (!job_ready);
    assign_room(start_t, finish_t, predicted);
    pending_assignments.push_back(known ? typed : predicted);
  endtask

  // Stops sending and waits until every owed result beat has been taken.
  task automatic wait_drained();
    job_valid <= 1'b0;
    do @(posedge clk); while (pending_assignments.size() != 0);
  endtask

  // The room count is only changed while the block has nothing in flight.
  task automatic write_room_count(input logic [CfgW-1:0] rooms);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= rooms;
    @(posedge clk);
    cfg_we <= 1'b0;
    room_count_reg = rooms;
  endtask

  function automatic void check_field(input string name, input logic [TimeW-1:0] want,
                                      input logic [TimeW-1:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Result side: checks each accepted beat against the oldest expectation and
  // throttles ready at random.
  always @(posedge clk) begin : result_check
    assignment_t want;
    if (rst_n && res_valid && res_ready) begin
      if (pending_assignments.size() == 0) begin
        failures++;
        $display("%0t: result beat with no job owed, expected none, actual %0h/%0h/%0h",
                 $time, res_room, res_begin, res_busiest);
      end else begin
        want = pending_assignments.pop_front();
        check_field("assigned_room", TimeW'(want.room), TimeW'(res_room));
        check_field("actual_begin", want.begin_at, res_begin);
        check_field("busiest_room", TimeW'(want.busiest), TimeW'(res_busiest));
      end
    end
    res_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t          row;
    assignment_t        typed;
    logic [InTimeW-1:0] sched_time;
    logic [InTimeW-1:0] start_t;
    logic [InTimeW-1:0] finish_t;
    logic [CfgW-1:0]    rooms;
    int unsigned        scale;
    int unsigned        stretch;
    int unsigned        n;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan: hand-picked corners, with the obvious answers typed in.
    for (int unsigned r = 0; r < DirectedRows; r++) begin
      row = directed_plan[r];
      if (row.kind == RowCfg) begin
        write_room_count(row.rooms);
      end else begin
        typed.room = row.room;
        typed.begin_at = row.begin_at;
        typed.busiest = row.busiest;
        send_job(row.start_t, row.finish_t, row.known, typed);
      end
    end

    // Random phases. Each one picks a room count, a time scale and a load.
    // Most jobs are well formed: ascending starts with random spacing and a
    // positive length sized so that rooms are sometimes free and sometimes
    // all taken. The rest are broken jobs: an out-of-order start, or a finish
    // that is not above the start.
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) rooms = CfgW'(RoomCap);
      else if (phase == 1) rooms = 5'd1;
      else if ($urandom_range(5) == 0) rooms = CfgW'($urandom_range(31));
      else rooms = CfgW'($urandom_range(RoomCap, 1));
      write_room_count(rooms);
      n = rooms_in_service();
      // One phase runs with no gaps or stalls at all.
      idle_pct = (phase == 5) ? 0 : IdlePct;
      // The last phases use coarse spacing so that start times climb into
      // the upper half of the 32-bit range.
      scale = (phase >= RandomPhases - 3) ? (1 << 24) : (1 << (2 + 4 * $urandom_range(4)));
      stretch = $urandom_range(2, 1);
      // Begin each phase once every room has drained, so the early jobs of
      // the phase find free rooms instead of a backlog from the last one.
      sched_time = '0;
      for (int unsigned i = 0; i < RoomCap; i++) begin
        if (room_free_time[i] > TimeW'(sched_time))
          sched_time = (room_free_time[i] > TimeW'(32'hFFFF_FFFF)) ? '1 :
                       room_free_time[i][InTimeW-1:0];
      end
      for (int unsigned k = 0; k < JobsPerPhase; k++) begin
        if ($urandom_range(99) < 85) begin
          sched_time = clamp_add(sched_time, $urandom_range(scale));
          start_t = sched_time;
          finish_t = clamp_add(sched_time, $urandom_range(scale * n * stretch, 1));
        end else if ($urandom_range(1) == 0) begin
          start_t = $urandom_range(sched_time);
          finish_t = $urandom();
        end else begin
          start_t = sched_time;
          finish_t = $urandom_range(sched_time);
        end
        send_job(start_t, finish_t, 1'b0, '0);
      end
    end

    // Long jobs: a single room takes back-to-back jobs of the longest
    // length, so its free time climbs well past the 32-bit input range.
    // This is also a long stretch with no gaps on either side.
    write_room_count(5'd1);
    idle_pct = 0;
    for (int unsigned k = 0; k < SatJobs; k++) send_job('0, '1, 1'b0, '0);

    // Let any stray beat show up before the verdict.
    wait_drained();
    repeat (RoomCap + 4) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
